// ===== rtl/core/cpsa_pkg.sv =====
// Shared types and constants for the compressed page store accounting block.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package cpsa_pkg;

  // Field widths of the item and result channels.
  localparam int MODE_W       = 2;
  localparam int PAGE_INDEX_W = 12;
  localparam int LENGTH_W     = 13;
  localparam int KIND_W       = 2;
  localparam int TOTAL_W      = 25;
  localparam int PAGES_W      = 13;

  // Default sizes handed to the top level parameters.
  localparam int MAX_PAGES_DEF  = 4096;
  localparam int PAGE_BYTES_DEF = 4096;

  // Each configured page adds 1 << ENTRY_SHIFT (16) to the memory total.
  localparam int ENTRY_SHIFT = 4;

  // Item mode codes.
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_COMP = 2'd2,
    KIND_RAW  = 2'd3
  } kind_e;

  // Operation after classification by the front end.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_SWEEP  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic [PAGE_INDEX_W-1:0] index;
    kind_e                   kind;
    logic [LENGTH_W-1:0]     len;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_in_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_out_t;

  typedef struct packed {
    logic sweeping;
    logic lookup;
  } bk_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpsa_ifs.sv =====
// Handshake interfaces for the item, result and configuration channels.
// Depends on cpsa_pkg for the field widths.
`default_nettype none

interface cpsa_req_if;
  logic                              valid;
  logic                              ready;
  logic [cpsa_pkg::MODE_W-1:0]       mode;
  logic [cpsa_pkg::PAGE_INDEX_W-1:0] page_index;
  logic                              page_is_zero;
  logic [cpsa_pkg::LENGTH_W-1:0]     compressed_length;

  modport source (output valid, mode, page_index, page_is_zero, compressed_length,
                  input ready);
  modport sink (input valid, mode, page_index, page_is_zero, compressed_length,
                output ready);
endinterface

interface cpsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [cpsa_pkg::KIND_W-1:0]   page_kind;
  logic [cpsa_pkg::LENGTH_W-1:0] stored_length;
  logic [cpsa_pkg::TOTAL_W-1:0]  original_total;
  logic [cpsa_pkg::TOTAL_W-1:0]  compressed_total;
  logic [cpsa_pkg::TOTAL_W-1:0]  memory_total;
  logic [cpsa_pkg::TOTAL_W-1:0]  peak_compressed;
  logic [cpsa_pkg::PAGES_W-1:0]  zero_page_count;
  logic [cpsa_pkg::PAGES_W-1:0]  raw_page_count;

  modport source (output valid, status, page_kind, stored_length, original_total,
                  compressed_total, memory_total, peak_compressed, zero_page_count,
                  raw_page_count, input ready);
  modport sink (input valid, status, page_kind, stored_length, original_total,
                compressed_total, memory_total, peak_compressed, zero_page_count,
                raw_page_count, output ready);
endinterface

interface cpsa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cpsa_pkg::PAGES_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cpsa_front.sv =====
// Front end: holds the page count register, accepts items and classifies them.
// Depends on cpsa_pkg and the interfaces in cpsa_ifs.
`default_nettype none

module cpsa_front #(
  parameter int MAX_PAGES  = cpsa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = cpsa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  cpsa_req_if.sink                           req,
  cpsa_cfg_if.sink                           cfg,
  input  wire logic                          q_full,
  output cpsa_pkg::q_in_t                    q_ctl,
  output cpsa_pkg::cmd_t                     q_cmd,
  output logic [cpsa_pkg::PAGES_W-1:0]       page_count
);
  import cpsa_pkg::*;

  logic in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= '0;
    end else if (cfg.valid) begin
      page_count <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;
  assign req.ready = !q_full;

  assign q_ctl.push = req.valid && !q_full;
  assign q_ctl.full = q_full;

  assign in_range = (page_count != '0)
                 && ({1'b0, req.page_index} < page_count)
                 && (32'(req.page_index) < MAX_PAGES);

  always_comb begin
    q_cmd.index = req.page_index;
    q_cmd.len   = '0;
    if (req.page_is_zero) begin
      q_cmd.kind = KIND_ZERO;
    end else if ((req.compressed_length != '0)
              && (32'(req.compressed_length) < PAGE_BYTES)) begin
      q_cmd.kind = KIND_COMP;
      q_cmd.len  = req.compressed_length;
    end else begin
      q_cmd.kind = KIND_RAW;
    end
    case (req.mode)
      MODE_CLEAR: q_cmd.op = OP_CLEAR;
      MODE_WRITE: q_cmd.op = in_range ? OP_WRITE : OP_REJECT;
      default:    q_cmd.op = in_range ? OP_QUERY : OP_REJECT;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpsa_cmd_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on cpsa_pkg for the command type.
`default_nettype none

module cpsa_cmd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cpsa_pkg::q_in_t in_ctl,
  input  wire cpsa_pkg::cmd_t  in_cmd,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output cpsa_pkg::cmd_t       head
);
  import cpsa_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = in_ctl.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpsa_back.sv =====
// Back end: page table memory, statistics counters, clearing sweep, result register.
// Depends on cpsa_pkg and the result interface in cpsa_ifs.
`default_nettype none

module cpsa_back #(
  parameter int MAX_PAGES  = cpsa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = cpsa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cpsa_pkg::cmd_t                head,
  input  wire logic                          q_empty,
  output cpsa_pkg::q_out_t                   q_ctl,
  input  wire logic [cpsa_pkg::PAGES_W-1:0]  page_count,
  output cpsa_pkg::bk_stat_t                 stat,
  cpsa_rsp_if.source                         rsp
);
  import cpsa_pkg::*;

  localparam int INDEX_SPAN = 1 << PAGE_INDEX_W;
  localparam int DEPTH      = (MAX_PAGES < INDEX_SPAN) ? MAX_PAGES : INDEX_SPAN;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_CAP    = (PAGE_BYTES < (1 << LENGTH_W)) ? PAGE_BYTES : (1 << LENGTH_W);
  localparam int LEN_W      = $clog2(LEN_CAP);
  localparam int ENTRY_W    = KIND_W + LEN_W;
  localparam int CNT_W      = $clog2(DEPTH * PAGE_BYTES + 1);
  localparam int PGC_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = ((CNT_W > PAGES_W + ENTRY_SHIFT) ? CNT_W
                                                                : PAGES_W + ENTRY_SHIFT) + 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] PAGE_COST = CNT_W'(PAGE_BYTES);

  logic [ENTRY_W-1:0] table_mem [DEPTH];

  state_e             state;
  state_e             state_next;
  logic [AW-1:0]      sweep_addr;
  cmd_t               cur;
  logic [ENTRY_W-1:0] rd_entry;
  logic [CNT_W-1:0]   comp_plus;

  logic [CNT_W-1:0]   orig;
  logic [CNT_W-1:0]   comp;
  logic [CNT_W-1:0]   peak;
  logic [PGC_W-1:0]   zero_cnt;
  logic [PGC_W-1:0]   raw_cnt;

  logic               fin;
  logic               fin_status;
  kind_e              fin_kind;
  logic [CNT_W-1:0]   fin_cost;

  // Sequencer controls.
  logic               rd_en;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               lookup_go;
  logic               out_free;

  // Lookup datapath.
  kind_e              old_kind;
  logic [LEN_W-1:0]   old_len;
  logic [CNT_W-1:0]   old_cost;
  logic [CNT_W-1:0]   new_cost;
  logic [CNT_W-1:0]   head_cost;
  logic               dec_zero;
  logic               dec_raw;
  logic               inc_zero;
  logic               inc_raw;
  logic [CNT_W-1:0]   peak_n;
  logic [SUM_W-1:0]   mem_sum;

  assign out_free = !rsp.valid || rsp.ready;

  assign old_kind = kind_e'(rd_entry[ENTRY_W-1 -: KIND_W]);
  assign old_len  = rd_entry[LEN_W-1:0];

  always_comb begin
    case (old_kind)
      KIND_COMP: old_cost = CNT_W'(old_len);
      KIND_RAW:  old_cost = PAGE_COST;
      default:   old_cost = '0;
    endcase
    case (cur.kind)
      KIND_COMP: new_cost = CNT_W'(cur.len);
      KIND_RAW:  new_cost = PAGE_COST;
      default:   new_cost = '0;
    endcase
    case (head.kind)
      KIND_COMP: head_cost = CNT_W'(head.len);
      KIND_RAW:  head_cost = PAGE_COST;
      default:   head_cost = '0;
    endcase
  end

  assign dec_zero = (old_kind == KIND_ZERO) && (zero_cnt != '0);
  assign dec_raw  = (old_kind == KIND_RAW) && (raw_cnt != '0);
  assign inc_zero = (cur.kind == KIND_ZERO);
  assign inc_raw  = (cur.kind == KIND_RAW);

  assign peak_n  = (comp > peak) ? comp : peak;
  assign mem_sum = SUM_W'(comp) + SUM_W'({page_count, ENTRY_SHIFT'(0)});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    q_ctl.pop      = 1'b0;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur.index[AW-1:0];
    mem_wdata      = {cur.kind, cur.len[LEN_W-1:0]};
    lookup_go      = 1'b0;
    stat.sweeping  = 1'b0;
    stat.lookup    = 1'b0;
    case (state)
      ST_SWEEP: begin
        stat.sweeping = 1'b1;
        mem_we        = 1'b1;
        mem_waddr     = sweep_addr;
        mem_wdata     = '0;
        if (sweep_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_ctl.pop  = 1'b1;
          rd_en      = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        stat.lookup = 1'b1;
        if (out_free) begin
          lookup_go = 1'b1;
          mem_we    = (cur.op == OP_WRITE);
          case (cur.op)
            OP_CLEAR: state_next = ST_SWEEP;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  assign q_ctl.empty = q_empty;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_entry <= table_mem[head.index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur       <= head;
      comp_plus <= comp + head_cost;
    end
    if (lookup_go) begin
      fin_status <= 1'b0;
      fin_kind   <= KIND_NONE;
      fin_cost   <= '0;
      case (cur.op)
        OP_WRITE: begin
          fin_kind <= cur.kind;
          fin_cost <= new_cost;
        end
        OP_QUERY: begin
          fin_kind <= old_kind;
          fin_cost <= old_cost;
        end
        OP_REJECT: begin
          fin_status <= 1'b1;
        end
        default: begin
          fin_status <= 1'b0;
        end
      endcase
    end
    if (fin) begin
      rsp.status           <= fin_status;
      rsp.page_kind        <= fin_kind;
      rsp.stored_length    <= LENGTH_W'(fin_cost);
      rsp.original_total   <= TOTAL_W'(orig);
      rsp.compressed_total <= TOTAL_W'(comp);
      rsp.memory_total     <= TOTAL_W'(mem_sum);
      rsp.peak_compressed  <= TOTAL_W'(peak_n);
      rsp.zero_page_count  <= PAGES_W'(zero_cnt);
      rsp.raw_page_count   <= PAGES_W'(raw_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      fin        <= 1'b0;
      rsp.valid  <= 1'b0;
      orig       <= '0;
      comp       <= '0;
      peak       <= '0;
      zero_cnt   <= '0;
      raw_cnt    <= '0;
    end else begin
      fin <= lookup_go;
      if (state == ST_SWEEP) begin
        sweep_addr <= (sweep_addr == LAST_ADDR) ? '0 : sweep_addr + AW'(1);
      end
      if (fin) begin
        peak      <= peak_n;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (lookup_go) begin
        case (cur.op)
          OP_WRITE: begin
            comp     <= (comp >= old_cost) ? comp_plus - old_cost : new_cost;
            orig     <= ((old_kind != KIND_NONE) && (orig >= PAGE_COST))
                        ? orig : orig + PAGE_COST;
            zero_cnt <= zero_cnt + PGC_W'(inc_zero) - PGC_W'(dec_zero);
            raw_cnt  <= raw_cnt + PGC_W'(inc_raw) - PGC_W'(dec_raw);
          end
          OP_CLEAR: begin
            comp     <= '0;
            orig     <= '0;
            peak     <= '0;
            zero_cnt <= '0;
            raw_cnt  <= '0;
          end
          default: begin
            comp <= comp;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/compressed_page_store_accounting_top.sv =====
// Top level of the compressed page store accounting block.
// Depends on cpsa_pkg, cpsa_ifs, cpsa_front, cpsa_cmd_queue and cpsa_back.
//
//   Channel   Direction   Carries
//   req       in          mode, page_index, page_is_zero, compressed_length
//   rsp       out         status, page_kind, stored_length and the statistics
//   cfg       in          page_count (13 bits)
//
// In the back end, ST_IDLE pops an item and reads the single-port page
// table; ST_LOOKUP then updates the entry (for a write) and the counters, waiting
// while a result is still held on rsp. The result passes the fin register into
// the rsp register; a new item is popped only back in ST_IDLE. A clear also sweeps
// all min(MAX_PAGES, 4096) table entries (4096 by default); a synchronous reset
// starts the same sweep, and no item is taken from the queue until it ends. The
// front end accepts items into a two-entry queue, until it is full, while the back
// end is busy or a result waits on rsp; configuration writes are taken in any cycle.
`default_nettype none

module compressed_page_store_accounting_top #(
  parameter int MAX_PAGES  = cpsa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = cpsa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cpsa_req_if.sink   req,
  cpsa_cfg_if.sink   cfg,
  cpsa_rsp_if.source rsp
);
  import cpsa_pkg::*;

  // Front end to queue.
  q_in_t                q_in;
  cmd_t                 q_cmd;
  logic                 q_full;
  logic                 q_empty;
  cmd_t                 q_head;

  // Back end to queue, and back end status for checking.
  q_out_t               q_out;
  bk_stat_t             bk_stat;
  logic [PAGES_W-1:0]   page_count;

  // The front end owns the page count register and classifies each item into
  // a write, query, clear or reject before it enters the queue.
  cpsa_front #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_ctl      (q_in),
    .q_cmd      (q_cmd),
    .page_count (page_count)
  );

  cpsa_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (q_in),
    .in_cmd (q_cmd),
    .pop    (q_out.pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (q_head)
  );

  // The back end holds the page table, the counters and the result register.
  cpsa_back #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_ctl      (q_out),
    .page_count (page_count),
    .stat       (bk_stat),
    .rsp        (rsp)
  );

`ifndef ASSERT_OFF
  // The front end must never push into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_in.push)
    else $error("command pushed into a full queue");

  // Nothing leaves the queue while the table is being swept.
  a_no_pop_sweep: assert property (@(posedge clk) disable iff (rst)
    bk_stat.sweeping |-> !q_out.pop)
    else $error("command popped during the table sweep");

  // A pop only happens with a command in the queue, and leads to a lookup.
  a_pop_lookup: assert property (@(posedge clk) disable iff (rst)
    q_out.pop |-> !q_empty ##1 bk_stat.lookup)
    else $error("queue pop without a following lookup");

  // A rejected item reports no page contents.
  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (rsp.page_kind == KIND_NONE && rsp.stored_length == '0))
    else $error("rejected item reports page contents");
`endif

endmodule

`default_nettype wire
